@@ sv/peer_heartbeat_watchdog_table_defines.svh @@
// assertion macros for the peer heartbeat watchdog table
// used by the top level only; empty bodies when SYNTH is defined
`ifndef PEER_HEARTBEAT_WATCHDOG_TABLE_DEFINES_SVH
`define PEER_HEARTBEAT_WATCHDOG_TABLE_DEFINES_SVH
`ifndef SYNTH
`define PHWT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("phwt check failed");
`define PHWT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("phwt check failed");
`else
`define PHWT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PHWT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/phwt_pkg.sv @@
// shared types and constants of the peer heartbeat watchdog table
// no dependencies
package phwt_pkg;

    localparam int ID_W   = 16;
    localparam int DROP_W = 8;
    localparam int PC_W   = 5;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 1;

    localparam logic OP_HB   = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_HB   = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [IDX_W-1:0] REG_OWN_ID    = 1'b0;
    localparam logic [IDX_W-1:0] REG_MAX_DROPS = 1'b1;

    localparam logic [DROP_W-1:0] MAX_DROPS_RST = 8'd9;

    // command codes handed from front to back
    localparam logic [1:0] CMD_HB   = 2'd0;
    localparam logic [1:0] CMD_SELF = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    typedef struct packed {
        logic [1:0]      code;
        logic [ID_W-1:0] peer_id;
    } t_cmd;

endpackage

@@ sv/phwt_in_if.sv @@
// input channel: heartbeat or tick beats
// depends on phwt_pkg
interface phwt_in_if;
    import phwt_pkg::*;

    logic            valid;
    logic            ready;
    logic            op;
    logic [ID_W-1:0] peer_id;

    modport source (output valid, output op, output peer_id, input ready);
    modport sink (input valid, input op, input peer_id, output ready);
endinterface

@@ sv/phwt_out_if.sv @@
// result channel: one beat per accepted item
// depends on phwt_pkg
interface phwt_out_if;
    import phwt_pkg::*;

    logic            valid;
    logic            ready;
    logic            kind;
    logic            lost;
    logic            newly_registered;
    logic            dropped_full;
    logic [PC_W-1:0] peer_count;

    modport source (output valid, output kind, output lost, output newly_registered,
                    output dropped_full, output peer_count, input ready);
    modport sink (input valid, input kind, input lost, input newly_registered,
                  input dropped_full, input peer_count, output ready);
endinterface

@@ sv/phwt_front.sv @@
// front end: takes input beats and classifies them into table commands
// depends on phwt_pkg, phwt_in_if
module phwt_front (
    phwt_in_if.sink                 i_item,
    input  logic [phwt_pkg::ID_W-1:0] i_own_id,
    input  logic                    i_q_full,
    output logic                    o_push,
    output phwt_pkg::t_cmd          o_cmd
);
    import phwt_pkg::*;

    assign i_item.ready = !i_q_full;
    assign o_push       = i_item.valid && !i_q_full;

    always_comb begin
        o_cmd.peer_id = i_item.peer_id;
        unique case (i_item.op)
            OP_TICK: o_cmd.code = CMD_TICK;
            OP_HB: begin
                // own heartbeats never touch the table
                o_cmd.code = (i_item.peer_id == i_own_id) ? CMD_SELF : CMD_HB;
            end
            default: o_cmd.code = CMD_TICK;
        endcase
    end
endmodule

@@ sv/phwt_queue.sv @@
// two-entry command queue between front and back
// depends on phwt_pkg
module phwt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  phwt_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output phwt_pkg::t_cmd o_cmd,
    output logic           o_empty,
    output logic           o_full
);
    import phwt_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_cnt, n_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_cnt    = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end
endmodule

@@ sv/phwt_back.sv @@
// back end: peer table with per-entry miss counters and the result register
// depends on phwt_pkg, phwt_out_if
module phwt_back #(
    parameter int MAX_PEERS  = 16,
    parameter int COUNT_BITS = 8,
    parameter int CNT_W      = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  phwt_pkg::t_cmd              i_cmd,
    input  logic [phwt_pkg::DROP_W-1:0] i_max_drops,
    output logic                        o_pop,
    output logic [MAX_PEERS-1:0]        o_valid_vec,
    output logic [CNT_W-1:0]            o_count,
    phwt_out_if.source                  o_res
);
    import phwt_pkg::*;

    localparam int CMP_W = (COUNT_BITS > DROP_W) ? COUNT_BITS : DROP_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [MAX_PEERS-1:0]  r_valid, n_valid;
    logic [ID_W-1:0]       r_id   [MAX_PEERS];
    logic [COUNT_BITS-1:0] r_miss [MAX_PEERS];
    logic [CNT_W-1:0]      r_count, n_count;

    logic                  r_out_valid;
    logic                  r_kind, r_lost, r_new, r_full;
    logic [CNT_W-1:0]      r_pc;

    logic [MAX_PEERS-1:0]  match, free_vec, free_sel, lost_vec;
    logic [COUNT_BITS-1:0] inc [MAX_PEERS];
    logic                  hit, tbl_full, is_hb, is_tick;
    logic                  n_kind, n_lost, n_new, n_full;

    assign o_pop = !i_q_empty && (!r_out_valid || o_res.ready);

    always_comb begin
        for (int i = 0; i < MAX_PEERS; i++) begin
            match[i]    = r_valid[i] && (r_id[i] == i_cmd.peer_id);
            inc[i]      = (r_miss[i] == CNT_MAX) ? CNT_MAX : r_miss[i] + COUNT_BITS'(1);
            lost_vec[i] = r_valid[i] && (CMP_W'(inc[i]) > CMP_W'(i_max_drops));
        end
        free_vec = ~r_valid;
        // isolate the lowest free entry
        free_sel = free_vec & (~free_vec + MAX_PEERS'(1));
        hit      = |match;
        tbl_full = ~|free_vec;
        is_hb    = (i_cmd.code == CMD_HB);
        is_tick  = (i_cmd.code == CMD_TICK);

        n_kind  = is_tick ? KIND_TICK : KIND_HB;
        n_lost  = is_tick && (|lost_vec);
        n_new   = is_hb && !hit && !tbl_full;
        n_full  = is_hb && !hit && tbl_full;
        n_valid = n_new ? (r_valid | free_sel) : r_valid;
        n_count = n_new ? r_count + CNT_W'(1) : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= n_valid;
                r_count <= n_count;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= n_kind;
            r_lost <= n_lost;
            r_new  <= n_new;
            r_full <= n_full;
            r_pc   <= n_count;
            for (int i = 0; i < MAX_PEERS; i++) begin
                if (is_tick && r_valid[i]) begin
                    r_miss[i] <= inc[i];
                end else if (is_hb && match[i]) begin
                    r_miss[i] <= '0;
                end else if (n_new && free_sel[i]) begin
                    r_miss[i] <= '0;
                    r_id[i]   <= i_cmd.peer_id;
                end
            end
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.kind             = r_kind;
    assign o_res.lost             = r_lost;
    assign o_res.newly_registered = r_new;
    assign o_res.dropped_full     = r_full;
    assign o_res.peer_count       = PC_W'(r_pc);

    assign o_valid_vec = r_valid;
    assign o_count     = r_count;
endmodule

@@ sv/peer_heartbeat_watchdog_table.sv @@
// peer heartbeat watchdog table: top level with config registers and checks
// path: a taken beat is written into the queue, then popped into the table and the result register
// throughput: one beat per cycle while the result channel is not stalled; the table updates with the result
// reset: synchronous active low; clears the table valid bits, peer count, queue
// and result valid flag, own_id to 0 and max_drops to 9; no clearing pass
`include "peer_heartbeat_watchdog_table_defines.svh"
module peer_heartbeat_watchdog_table #(
    parameter int MAX_PEERS  = 16,
    parameter int COUNT_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [phwt_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [phwt_pkg::CFG_W-1:0] i_cfg_data,
    phwt_in_if.sink                    i_item,
    phwt_out_if.source                 o_res
);
    import phwt_pkg::*;

    localparam int CNT_W = $clog2(MAX_PEERS + 1);

    logic [ID_W-1:0]      r_own_id;
    logic [DROP_W-1:0]    r_max_drops;

    logic                 push, pop, q_empty, q_full;
    t_cmd                 front_cmd, q_cmd;
    logic [MAX_PEERS-1:0] valid_vec;
    logic [CNT_W-1:0]     count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id    <= '0;
            r_max_drops <= MAX_DROPS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OWN_ID:    r_own_id    <= i_cfg_data[ID_W-1:0];
                REG_MAX_DROPS: r_max_drops <= i_cfg_data[DROP_W-1:0];
                default: ;
            endcase
        end
    end

    phwt_front u_front (
        .i_item   (i_item),
        .i_own_id (r_own_id),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    phwt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    phwt_back #(
        .MAX_PEERS  (MAX_PEERS),
        .COUNT_BITS (COUNT_BITS),
        .CNT_W      (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (q_cmd),
        .i_max_drops (r_max_drops),
        .o_pop       (pop),
        .o_valid_vec (valid_vec),
        .o_count     (count),
        .o_res       (o_res)
    );

    // peer count always tracks the valid entries
    `PHWT_ASSERT_IMP(a_count_matches, i_clk, i_rst_n, 1'b1, $countones(valid_vec) == count)
    // a dropped peer is only reported with a full table
    `PHWT_ASSERT_IMP(a_drop_when_full, i_clk, i_rst_n, o_res.valid && o_res.dropped_full, &valid_vec)
    // an accepted beat into an empty queue is held somewhere next cycle
    `PHWT_ASSERT_NXT(a_beat_kept, i_clk, i_rst_n, push && q_empty, !q_empty || o_res.valid)
endmodule

@@ tb/tb_peer_heartbeat_watchdog_table.sv @@
// testbench for peer_heartbeat_watchdog_table: directed and random heartbeat/tick traffic
// with a built-in table predictor and a result checker
// depends on phwt_pkg, phwt_in_if, phwt_out_if and the top level
module tb_peer_heartbeat_watchdog_table;
    timeunit 1ns;
    timeprecision 1ps;

    import phwt_pkg::*;

    localparam int MAX_PEERS  = 16;
    localparam int COUNT_BITS = 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int POOL_SIZE  = 24;
    localparam int GAP_MAX    = 20;

    typedef struct packed {
        logic            kind;
        logic            lost;
        logic            newly_registered;
        logic            dropped_full;
        logic [PC_W-1:0] peer_count;
    } t_watch_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    phwt_in_if  hb_in ();
    phwt_out_if watch_out ();

    // mirror of the block's table and registers
    logic [ID_W-1:0]       own_id_q;
    logic [DROP_W-1:0]     max_drops_q;
    logic                  slot_used [MAX_PEERS];
    logic [ID_W-1:0]       slot_id [MAX_PEERS];
    logic [COUNT_BITS-1:0] slot_misses [MAX_PEERS];
    int unsigned           peers_known;

    t_watch_result   pending_results [$];
    logic [ID_W-1:0] peer_pool [POOL_SIZE];
    int              mismatch_count;
    int              send_idle_pct;
    int              recv_stall_pct;

    peer_heartbeat_watchdog_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (hb_in),
        .o_res      (watch_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // updates the mirrored table for one beat and returns the result it should give
    function automatic t_watch_result predict_watch(logic op, logic [ID_W-1:0] id);
        t_watch_result r;
        int            free_slot;
        logic          hit;
        r = '0;
        free_slot = -1;
        hit = 1'b0;
        if (op == OP_TICK) begin
            r.kind = KIND_TICK;
            for (int i = 0; i < MAX_PEERS; i++) begin
                if (slot_used[i]) begin
                    if (slot_misses[i] < COUNT_MAX)
                        slot_misses[i] = slot_misses[i] + 1'b1;
                    if (slot_misses[i] > max_drops_q)
                        r.lost = 1'b1;
                end
            end
        end else begin
            r.kind = KIND_HB;
            if (id != own_id_q) begin
                for (int i = 0; i < MAX_PEERS; i++) begin
                    if (!hit && slot_used[i] && slot_id[i] == id) begin
                        slot_misses[i] = '0;
                        hit = 1'b1;
                    end else if (!slot_used[i] && free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (!hit) begin
                    if (free_slot < 0) begin
                        r.dropped_full = 1'b1;
                    end else begin
                        slot_used[free_slot] = 1'b1;
                        slot_id[free_slot] = id;
                        slot_misses[free_slot] = '0;
                        peers_known++;
                        r.newly_registered = 1'b1;
                    end
                end
            end
        end
        r.peer_count = PC_W'(peers_known);
        return r;
    endfunction

    function automatic logic is_registered(logic [ID_W-1:0] id);
        for (int i = 0; i < MAX_PEERS; i++)
            if (slot_used[i] && slot_id[i] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    // one beat on the input channel, with a random lead-in gap
    task automatic send_beat(logic op, logic [ID_W-1:0] id);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < send_idle_pct)
            gap++;
        repeat (gap) begin
            hb_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        hb_in.valid   <= 1'b1;
        hb_in.op      <= op;
        hb_in.peer_id <= id;
        do @(posedge i_clk); while (hb_in.ready !== 1'b1);
        pending_results.push_back(predict_watch(op, id));
    endtask

    task automatic drain_results();
        hb_in.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic set_config(logic [ID_W-1:0] own, logic [DROP_W-1:0] drops);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_OWN_ID;
        i_cfg_data <= own;
        @(posedge i_clk);
        i_cfg_idx  <= REG_MAX_DROPS;
        i_cfg_data <= CFG_W'(drops);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        own_id_q = own;
        max_drops_q = drops;
    endtask

    always @(posedge i_clk) begin : result_check
        t_watch_result got;
        t_watch_result want;
        if (i_rst_n === 1'b1 && watch_out.valid === 1'b1 && watch_out.ready === 1'b1) begin
            got = {watch_out.kind, watch_out.lost, watch_out.newly_registered,
                   watch_out.dropped_full, watch_out.peer_count};
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected result beat kind=%0d lost=%0d new=%0d ",
                             $realtime, got.kind, got.lost, got.newly_registered,
                             "full=%0d count=%0d", got.dropped_full, got.peer_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    if (mismatch_count < 10)
                        $display("%0t: mismatch exp kind=%0d lost=%0d new=%0d full=%0d ",
                                 $realtime, want.kind, want.lost, want.newly_registered,
                                 want.dropped_full,
                                 "count=%0d / got kind=%0d lost=%0d new=%0d full=%0d ",
                                 want.peer_count, got.kind, got.lost,
                                 got.newly_registered, got.dropped_full,
                                 "count=%0d", got.peer_count);
                    mismatch_count++;
                end
            end
        end
        watch_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // defaults after reset: own id 0 ignored, all-ones id registers, loss after ten ticks
    task automatic test_reset_state();
        send_idle_pct = 9;
        recv_stall_pct = 9;
        send_beat(OP_TICK, 16'hFFFF);
        send_beat(OP_HB, 16'h0000);
        send_beat(OP_HB, 16'hFFFF);
        send_beat(OP_HB, 16'hFFFF);
        repeat (10) send_beat(OP_TICK, 16'h0000);
        send_beat(OP_HB, 16'hFFFF);
        send_beat(OP_TICK, 16'h1234);
    endtask

    // own id matching a registered peer, and a zero drop limit
    task automatic test_own_id_and_zero_limit();
        set_config(16'hFFFF, 8'd0);
        send_beat(OP_HB, 16'hFFFF);
        send_beat(OP_TICK, 16'h0000);
        send_beat(OP_HB, 16'h0000);
        send_beat(OP_HB, 16'h5555);
        send_beat(OP_HB, 16'hAAAA);
        send_beat(OP_TICK, 16'hFFFF);
    endtask

    task automatic test_random_traffic();
        int              pick;
        int              pause_at;
        logic [ID_W-1:0] own;
        logic [DROP_W-1:0] drops;
        foreach (peer_pool[k])
            peer_pool[k] = ID_W'($urandom);
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            case ($urandom_range(4))
                0: drops = 8'd0;
                1: drops = 8'd3;
                2: drops = MAX_DROPS_RST;
                3: drops = 8'd30;
                default: drops = DROP_W'($urandom_range(254));
            endcase
            own = $urandom_range(1) ? peer_pool[$urandom_range(POOL_SIZE-1)] : ID_W'($urandom);
            set_config(own, drops);
            pause_at = $urandom_range(5, 20);
            for (int n = 0; n < 25; n++) begin
                if (n == pause_at)
                    drain_results();
                pick = $urandom_range(99);
                if (pick < 35)
                    send_beat(OP_TICK, ID_W'($urandom));
                else if (pick < 45)
                    send_beat(OP_HB, own_id_q);
                else if (pick < 60)
                    send_beat(OP_HB, ID_W'($urandom));
                else
                    send_beat(OP_HB, peer_pool[$urandom_range(POOL_SIZE-1)]);
            end
        end
    endtask

    task automatic test_table_full();
        logic [ID_W-1:0] id;
        send_idle_pct = 9;
        recv_stall_pct = 9;
        set_config(16'h8001, MAX_DROPS_RST);
        while (peers_known < MAX_PEERS) begin
            id = ID_W'($urandom);
            if (!is_registered(id) && id != own_id_q)
                send_beat(OP_HB, id);
        end
        do id = ID_W'($urandom); while (is_registered(id) || id == own_id_q);
        send_beat(OP_HB, id);
        send_beat(OP_HB, own_id_q);
        send_beat(OP_HB, slot_id[$urandom_range(MAX_PEERS-1)]);
        send_beat(OP_TICK, ID_W'($urandom));
    endtask

    // counters pinned at all-ones: never lost at limit 255, lost at 254
    task automatic test_counter_saturation();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_config(own_id_q, 8'hFF);
        repeat (258) send_beat(OP_TICK, ID_W'($urandom));
        set_config(own_id_q, 8'd254);
        send_beat(OP_TICK, 16'h0000);
        send_beat(OP_HB, slot_id[0]);
        send_beat(OP_TICK, 16'hFFFF);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = REG_OWN_ID;
        i_cfg_data       = '0;
        hb_in.valid      = 1'b0;
        hb_in.op         = OP_HB;
        hb_in.peer_id    = '0;
        own_id_q         = '0;
        max_drops_q      = MAX_DROPS_RST;
        foreach (slot_used[k]) begin
            slot_used[k]   = 1'b0;
            slot_id[k]     = '0;
            slot_misses[k] = '0;
        end
        peers_known      = 0;
        mismatch_count   = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_own_id_and_zero_limit();
        test_random_traffic();
        test_table_full();
        test_counter_saturation();

        drain_results();
        // tail: catch any stray beat after the last expected one
        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
